// File: hw/rtl/nfa_pkg.sv
//------------------------------------------------------------------------------
// nfa_pkg
// Shared types and codes for the NOR flash array model: field widths,
// operation and status codes, controller command and status bundles.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfa_pkg;

  // Field widths of one transfer
  localparam int FUNC_W   = 3;
  localparam int ADDR_W   = 17;
  localparam int BYTE_W   = 8;
  localparam int END_W    = 18;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_SECTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TOTAL      = 2'd2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BLOCK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SECTOR = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEVICE = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDRESS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SECTOR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_BLOCK   = 3'd4;

  // Erased byte value
  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch incoming transfer, start array read
    logic out_load;   // capture result, commit write or start erase
    logic walk_step;  // erase one byte and advance the walker
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic erase_go;   // current item needs an erase walk
    logic walk_zero;  // walker has nothing left
    logic walk_last;  // walker is on its final byte
  } stat_t;

endpackage

// File: hw/rtl/nfa_ram.sv
//------------------------------------------------------------------------------
// nfa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/nfa_geom.sv
//------------------------------------------------------------------------------
// nfa_geom
// Geometry registers: effective block size, blocks per sector and sector
// count, plus the registered products derived from them.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_geom
  import nfa_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES      = 512,
  parameter int MAX_BLOCKS_IN_SECTOR = 16,
  parameter int MAX_SECTORS          = 16,
  localparam int BW = $clog2(MAX_BLOCK_BYTES + 1),
  localparam int NW = $clog2(MAX_BLOCKS_IN_SECTOR + 1),
  localparam int SW = $clog2(MAX_SECTORS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_accept,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [BW-1:0]         blk,        // effective block bytes
  output logic [SW-1:0]         sec,        // effective sector count
  output logic [BW+NW-1:0]      sec_bytes,  // bytes per sector
  output logic [NW+SW-1:0]      nblk,       // blocks in device
  output logic [BW+NW+SW-1:0]   size,       // device bytes
  output logic                  busy        // products still settling
);

  logic [NW-1:0] bps;
  logic [10:0]   blk_round;
  logic [1:0]    settle;

  // round block size up to a multiple of 64
  assign blk_round = {5'(cfg_data[9:6]) + 5'(|cfg_data[5:0]), 6'b0};

  // register writes, capped on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      blk <= '0;
      bps <= '0;
      sec <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        REG_BLOCK_BYTES: begin
          if (32'(blk_round) > MAX_BLOCK_BYTES) blk <= BW'(MAX_BLOCK_BYTES);
          else blk <= BW'(blk_round);
        end
        REG_BLOCKS_PER_SECTOR: begin
          if (32'(cfg_data[4:0]) > MAX_BLOCKS_IN_SECTOR) begin
            bps <= NW'(MAX_BLOCKS_IN_SECTOR);
          end else begin
            bps <= NW'(cfg_data[4:0]);
          end
        end
        REG_SECTOR_TOTAL: begin
          if (32'(cfg_data[4:0]) > MAX_SECTORS) sec <= SW'(MAX_SECTORS);
          else sec <= SW'(cfg_data[4:0]);
        end
        default: ;
      endcase
    end
  end

  // products, one multiplier per register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_bytes <= '0;
      nblk      <= '0;
      size      <= '0;
    end else begin
      sec_bytes <= (BW+NW)'(blk) * (BW+NW)'(bps);
      nblk      <= (NW+SW)'(bps) * (NW+SW)'(sec);
      size      <= (BW+NW+SW)'(sec_bytes) * (BW+NW+SW)'(sec);
    end
  end

  // hold off items until the product chain has caught up
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (cfg_accept) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy = (settle != 2'd0);

endmodule

// File: hw/rtl/nfa_datapath.sv
//------------------------------------------------------------------------------
// nfa_datapath
// Item registers, range checks, array RAM with read-modify-write path,
// erase address walker and result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_datapath
  import nfa_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES      = 512,
  parameter int MAX_BLOCKS_IN_SECTOR = 16,
  parameter int MAX_SECTORS          = 16,
  localparam int BW = $clog2(MAX_BLOCK_BYTES + 1),
  localparam int NW = $clog2(MAX_BLOCKS_IN_SECTOR + 1),
  localparam int SW = $clog2(MAX_SECTORS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ADDR_W-1:0]   in_byte_address,
  input  logic [BYTE_W-1:0]   in_write_byte,
  input  logic [END_W-1:0]    in_span_end,
  input  logic [IDX_W-1:0]    in_erase_index,
  input  logic [BW-1:0]       blk,
  input  logic [SW-1:0]       sec,
  input  logic [BW+NW-1:0]    sec_bytes,
  input  logic [NW+SW-1:0]    nblk,
  input  logic [BW+NW+SW-1:0] size,
  output logic [STATUS_W-1:0] status,
  output logic [BYTE_W-1:0]   read_data
);

  localparam int DEPTH = MAX_BLOCK_BYTES * MAX_BLOCKS_IN_SECTOR * MAX_SECTORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = BW + NW + SW;
  localparam int CW    = (LW > END_W) ? LW : END_W;

  logic [FUNC_W-1:0]   func_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [BYTE_W-1:0]   wbyte_q;
  logic [END_W-1:0]    end_q;
  logic [IDX_W-1:0]    idx_q;

  logic [STATUS_W-1:0] status_c;
  logic                ok_c;
  logic                rmw_wr;

  logic [BW+IDX_W-1:0]    blk_start;
  logic [BW+NW+IDX_W-1:0] sec_start;

  logic [AW-1:0]     walk_addr;
  logic [LW-1:0]     walk_left;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic [BYTE_W-1:0] ram_rd_data;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q  <= in_func;
      addr_q  <= in_byte_address;
      wbyte_q <= in_write_byte;
      end_q   <= in_span_end;
      idx_q   <= in_erase_index;
    end
  end

  // range checks against the current geometry
  always_comb begin
    unique case (func_q)
      FN_WRITE, FN_READ: begin
        if (size == '0) begin
          status_c = ST_NO_MEMORY;
        end else if ((CW'(end_q) > CW'(size)) || (CW'(addr_q) >= CW'(size))) begin
          status_c = ST_BAD_ADDRESS;
        end else begin
          status_c = ST_OK;
        end
      end
      FN_BLOCK:  status_c = (32'(idx_q) >= 32'(nblk)) ? ST_BAD_BLOCK : ST_OK;
      FN_SECTOR: status_c = (32'(idx_q) >= 32'(sec)) ? ST_BAD_SECTOR : ST_OK;
      default:   status_c = ST_OK;
    endcase
  end

  assign ok_c = (status_c == ST_OK);

  assign stat.erase_go = ok_c &&
      ((func_q == FN_BLOCK) || (func_q == FN_SECTOR) || (func_q == FN_DEVICE));

  // erase region start addresses
  assign blk_start = (BW+IDX_W)'(blk) * (BW+IDX_W)'(idx_q);
  assign sec_start = (BW+NW+IDX_W)'(sec_bytes) * (BW+NW+IDX_W)'(idx_q);

  // erase walker; after reset it covers the whole array
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr <= '0;
      walk_left <= LW'(DEPTH);
    end else if (cmd.out_load && stat.erase_go) begin
      unique case (func_q)
        FN_BLOCK: begin
          walk_addr <= AW'(blk_start);
          walk_left <= LW'(blk);
        end
        FN_SECTOR: begin
          walk_addr <= AW'(sec_start);
          walk_left <= LW'(sec_bytes);
        end
        default: begin
          walk_addr <= '0;
          walk_left <= size;
        end
      endcase
    end else if (cmd.walk_step) begin
      walk_addr <= walk_addr + AW'(1);
      walk_left <= walk_left - LW'(1);
    end
  end

  assign stat.walk_zero = (walk_left == '0);
  assign stat.walk_last = (walk_left == LW'(1));

  // array write: erase byte or AND the new byte into the old one
  assign rmw_wr      = cmd.out_load && (func_q == FN_WRITE) && ok_c;
  assign ram_wr_en   = rmw_wr || cmd.walk_step;
  assign ram_wr_addr = cmd.walk_step ? walk_addr : AW'(addr_q);
  assign ram_wr_data = cmd.walk_step ? ERASED_BYTE : (ram_rd_data & wbyte_q);

  nfa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_array (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (AW'(in_byte_address)),
    .rd_data (ram_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= status_c;
      if ((func_q == FN_READ) && ok_c) read_data <= ram_rd_data;
      else read_data <= '0;
    end
  end

endmodule

// File: hw/rtl/nfa_ctrl.sv
//------------------------------------------------------------------------------
// nfa_ctrl
// Controller: sequences accept, check/commit and erase walk, and owns the
// handshake of both streams.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_ctrl
  import nfa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  geo_busy,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [1:0] {
    S_ERASE,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // commands
  assign s_tready      = (state == S_IDLE) && !geo_busy;
  assign cmd.accept    = s_tvalid && s_tready;
  assign cmd.out_load  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign cmd.walk_step = (state == S_ERASE) && !stat.walk_zero;

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ERASE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_ERASE: begin
          if (stat.walk_zero || stat.walk_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.accept) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.out_load) state <= stat.erase_go ? S_ERASE : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/nor_flash_array_model.sv
//------------------------------------------------------------------------------
// nor_flash_array_model
// Byte-wide NOR flash array with configurable block/sector geometry.
//------------------------------------------------------------------------------
// One item at a time. A byte write or read is accepted in S_IDLE, which
// starts the array read; in S_EXEC, once the output register is free, the
// datapath checks the range, writes the ANDed byte back and loads the
// result register. Erases then walk their region through the single array
// write port at one byte per cycle: a block erase covers the effective
// block size, a sector erase block size times blocks per sector, a device
// erase the configured array size; an empty region still passes through
// S_ERASE. After reset the array is cleared to 0xFF by the same walker over
// the full depth (MAX_BLOCK_BYTES*MAX_BLOCKS_IN_SECTOR*MAX_SECTORS bytes,
// 131072 by default), and s_tready stays low until it is done.
// A configuration transfer holds s_tready low while the geometry products
// settle. A finished result may wait in the output register while the next
// item is accepted.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module nor_flash_array_model
  import nfa_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES      = 512,
  parameter int MAX_BLOCKS_IN_SECTOR = 16,
  parameter int MAX_SECTORS          = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // func, byte_address, write_byte,
                                           // span_end, erase_index, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // status, read_data, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int NW = $clog2(MAX_BLOCKS_IN_SECTOR + 1);
  localparam int SW = $clog2(MAX_SECTORS + 1);

  cmd_t  cmd;
  stat_t stat;

  logic [BW-1:0]       blk;
  logic [SW-1:0]       sec;
  logic [BW+NW-1:0]    sec_bytes;
  logic [NW+SW-1:0]    nblk;
  logic [BW+NW+SW-1:0] size;
  logic                geo_busy;

  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_data;

  // config writes always taken
  assign cfg_ready = 1'b1;

  nfa_geom #(
    .MAX_BLOCK_BYTES      (MAX_BLOCK_BYTES),
    .MAX_BLOCKS_IN_SECTOR (MAX_BLOCKS_IN_SECTOR),
    .MAX_SECTORS          (MAX_SECTORS)
  ) u_geom (
    .clk        (clk),
    .rst        (rst),
    .cfg_accept (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .blk        (blk),
    .sec        (sec),
    .sec_bytes  (sec_bytes),
    .nblk       (nblk),
    .size       (size),
    .busy       (geo_busy)
  );

  nfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .geo_busy (geo_busy),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  nfa_datapath #(
    .MAX_BLOCK_BYTES      (MAX_BLOCK_BYTES),
    .MAX_BLOCKS_IN_SECTOR (MAX_BLOCKS_IN_SECTOR),
    .MAX_SECTORS          (MAX_SECTORS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (s_tdata[2:0]),
    .in_byte_address (s_tdata[19:3]),
    .in_write_byte   (s_tdata[27:20]),
    .in_span_end     (s_tdata[45:28]),
    .in_erase_index  (s_tdata[53:46]),
    .blk             (blk),
    .sec             (sec),
    .sec_bytes       (sec_bytes),
    .nblk            (nblk),
    .size            (size),
    .status          (status),
    .read_data       (read_data)
  );

  // result packing
  assign m_tdata = {5'b0, read_data, status};

endmodule
